// ===== rtl/obb_pkg.sv =====
// Shared types, widths and the arctangent table for the oriented box overlap test.
// No dependencies; imported by every rtl module except obb_checker.
`timescale 1ns / 1ps
package obb_pkg;
    localparam int T   = 15;              // sine/cosine fraction bits
    localparam int TW  = T + 2;           // sine/cosine width, holds +-2^T
    localparam int XW  = 34;              // CORDIC x/y width, Q30
    localparam int ZW  = 33;              // CORDIC angle width
    localparam int NIT = 30;              // CORDIC iterations
    localparam int CW  = 26;              // corner coordinate width
    localparam int PW  = 17 + TW;         // size times trig product
    localparam int DW  = PW + 1;          // corner offset sum
    localparam int PRW = CW + TW;         // projection product
    localparam int SW  = PRW + 1;         // projection sum
    localparam int OW  = SW + 1;          // overlap width
    localparam int EW  = 16;              // epsilon width
    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

    typedef struct packed {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [15:0]        w;
        logic [15:0]        l;
    } t_geom;

    typedef struct packed {
        logic [3:0][CW-1:0] px;
        logic [3:0][CW-1:0] py;
        logic [1:0][TW-1:0] ax;
        logic [1:0][TW-1:0] ay;
    } t_box;

    function automatic logic signed [ZW-1:0] atan_turn(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0: v = ZW'(536870912);  1: v = ZW'(316933406);  2: v = ZW'(167458907);
            3: v = ZW'(85004756);   4: v = ZW'(42667331);   5: v = ZW'(21354465);
            6: v = ZW'(10679838);   7: v = ZW'(5340245);    8: v = ZW'(2670163);
            9: v = ZW'(1335087);    10: v = ZW'(667544);    11: v = ZW'(333772);
            12: v = ZW'(166886);    13: v = ZW'(83443);     14: v = ZW'(41722);
            15: v = ZW'(20861);     16: v = ZW'(10430);     17: v = ZW'(5215);
            18: v = ZW'(2608);      19: v = ZW'(1304);      20: v = ZW'(652);
            21: v = ZW'(326);       22: v = ZW'(163);       23: v = ZW'(81);
            24: v = ZW'(41);        25: v = ZW'(20);        26: v = ZW'(10);
            27: v = ZW'(5);         28: v = ZW'(3);         29: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

// ===== rtl/obb_cordic.sv =====
// Pipelined rotation CORDIC: heading to Q.T cosine and sine, geometry carried alongside.
// Depends on obb_pkg. Registered stages: pre-rotation, 30 iterations, rounding.
`timescale 1ns / 1ps
module obb_cordic import obb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_adv,
    input  logic [15:0]          i_heading,
    input  t_geom                i_geom,
    output logic signed [TW-1:0] o_cos,
    output logic signed [TW-1:0] o_sin,
    output t_geom                o_geom
);
    localparam int S = 30 - T;

    logic signed [XW-1:0] r_x [NIT+1];
    logic signed [XW-1:0] r_y [NIT+1];
    logic signed [ZW-1:0] r_z [NIT+1];
    logic                 r_flip [NIT+1];
    t_geom                r_geom [NIT+1];
    logic signed [TW-1:0] r_cos, r_sin;
    t_geom                r_geom_out;

    logic signed [ZW-1:0] n_z0;
    logic                 n_flip0;

    always_comb begin
        n_z0    = ZW'($signed({i_heading, 16'h0000}));
        n_flip0 = 1'b0;
        if (n_z0 > (ZW'(1) <<< 30)) begin
            n_z0    = n_z0 - (ZW'(1) <<< 31);
            n_flip0 = 1'b1;
        end else if (n_z0 < -(ZW'(1) <<< 30)) begin
            n_z0    = n_z0 + (ZW'(1) <<< 31);
            n_flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x[0]    <= CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= n_z0;
            r_flip[0] <= n_flip0;
            r_geom[0] <= i_geom;
        end
    end

    for (genvar i = 0; i < NIT; i++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_turn(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_turn(i);
                end
                r_flip[i+1] <= r_flip[i];
                r_geom[i+1] <= r_geom[i];
            end
        end
    end

    function automatic logic signed [TW-1:0] to_trig(input logic signed [XW-1:0] q);
        logic signed [XW:0] r;
        r = ((XW+1)'(q) + ((XW+1)'(1) <<< (S-1))) >>> S;
        if (r > ((XW+1)'(1) <<< T))       r = (XW+1)'(1) <<< T;
        else if (r < -((XW+1)'(1) <<< T)) r = -((XW+1)'(1) <<< T);
        return r[TW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cos      <= to_trig(r_flip[NIT] ? -r_x[NIT] : r_x[NIT]);
            r_sin      <= to_trig(r_flip[NIT] ? -r_y[NIT] : r_y[NIT]);
            r_geom_out <= r_geom[NIT];
        end
    end

    assign o_cos  = r_cos;
    assign o_sin  = r_sin;
    assign o_geom = r_geom_out;
endmodule

// ===== rtl/obb_box.sv =====
// Box builder: four corners and two test axes from centre, size and cos/sin.
// Depends on obb_pkg. Registers the products, then the corners and axes.
`timescale 1ns / 1ps
module obb_box import obb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_adv,
    input  logic [EW-1:0]        i_eps,
    input  logic signed [TW-1:0] i_cos,
    input  logic signed [TW-1:0] i_sin,
    input  t_geom                i_geom,
    output t_box                 o_box
);
    logic signed [PW-1:0] r_lc, r_ls, r_wc, r_ws;
    logic signed [TW-1:0] r_c, r_s;
    logic                 r_wok, r_lok;
    logic signed [23:0]   r_cx, r_cy;
    t_box                 r_box;
    t_box                 n_box;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lc  <= $signed({1'b0, i_geom.l}) * i_cos;
            r_ls  <= $signed({1'b0, i_geom.l}) * i_sin;
            r_wc  <= $signed({1'b0, i_geom.w}) * i_cos;
            r_ws  <= $signed({1'b0, i_geom.w}) * i_sin;
            r_c   <= i_cos;
            r_s   <= i_sin;
            r_wok <= i_geom.w > i_eps;
            r_lok <= i_geom.l > i_eps;
            r_cx  <= i_geom.cx;
            r_cy  <= i_geom.cy;
        end
    end

    function automatic logic [CW-1:0] corner(input logic signed [23:0] ctr,
                                             input logic signed [DW-1:0] d);
        logic signed [DW-1:0] h;
        h = (d + (DW'(1) <<< T)) >>> (T + 1);
        return CW'(ctr) + h[CW-1:0];
    endfunction

    always_comb begin
        logic signed [DW-1:0] lc, ls, wc, ws;
        lc = DW'(r_lc);
        ls = DW'(r_ls);
        wc = DW'(r_wc);
        ws = DW'(r_ws);
        // corner order (+,+), (+,-), (-,-), (-,+) in length, width
        n_box.px[0] = corner(r_cx,  lc + ws);
        n_box.py[0] = corner(r_cy,  ls - wc);
        n_box.px[1] = corner(r_cx,  lc - ws);
        n_box.py[1] = corner(r_cy,  ls + wc);
        n_box.px[2] = corner(r_cx, -lc - ws);
        n_box.py[2] = corner(r_cy, -ls + wc);
        n_box.px[3] = corner(r_cx, -lc + ws);
        n_box.py[3] = corner(r_cy, -ls - wc);
        n_box.ax[0] = r_wok ? -r_c : '0;
        n_box.ay[0] = r_wok ? -r_s : '0;
        n_box.ax[1] = r_lok ? r_s : '0;
        n_box.ay[1] = r_lok ? -r_c : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) r_box <= n_box;
    end

    assign o_box = r_box;
endmodule

// ===== rtl/obb_lane.sv =====
// One axis lane: projects both boxes onto an axis and checks the overlap against epsilon.
// Depends on obb_pkg. Registered stages: products, sums, min/max, overlap compare.
`timescale 1ns / 1ps
module obb_lane import obb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_adv,
    input  logic [EW-1:0]        i_eps,
    input  t_box                 i_box_a,
    input  t_box                 i_box_b,
    input  logic signed [TW-1:0] i_ax,
    input  logic signed [TW-1:0] i_ay,
    output logic                 o_fail
);
    logic signed [PRW-1:0] r_mx [8];
    logic signed [PRW-1:0] r_my [8];
    logic signed [SW-1:0]  r_p  [8];
    logic signed [SW-1:0]  r_alo, r_ahi, r_blo, r_bhi;
    logic                  r_fail;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < 4; k++) begin
                r_mx[k]   <= $signed(i_box_a.px[k]) * i_ax;
                r_my[k]   <= $signed(i_box_a.py[k]) * i_ay;
                r_mx[k+4] <= $signed(i_box_b.px[k]) * i_ax;
                r_my[k+4] <= $signed(i_box_b.py[k]) * i_ay;
            end
            for (int k = 0; k < 8; k++) begin
                r_p[k] <= SW'(r_mx[k]) + SW'(r_my[k]);
            end
        end
    end

    function automatic logic signed [SW-1:0] mn(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
        return (a < b) ? a : b;
    endfunction
    function automatic logic signed [SW-1:0] mx(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_alo <= mn(mn(r_p[0], r_p[1]), mn(r_p[2], r_p[3]));
            r_ahi <= mx(mx(r_p[0], r_p[1]), mx(r_p[2], r_p[3]));
            r_blo <= mn(mn(r_p[4], r_p[5]), mn(r_p[6], r_p[7]));
            r_bhi <= mx(mx(r_p[4], r_p[5]), mx(r_p[6], r_p[7]));
        end
    end

    logic signed [OW-1:0] n_ov, n_limit;
    always_comb begin
        n_limit = $signed({{(OW-EW-T){1'b0}}, i_eps, {T{1'b0}}});
        if (r_alo > r_bhi || r_ahi < r_blo) n_ov = '0;
        else n_ov = OW'(mn(r_ahi, r_bhi)) - OW'(mx(r_alo, r_blo));
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) r_fail <= n_ov < n_limit;
    end

    assign o_fail = r_fail;
endmodule

// ===== rtl/obb_overlap_test.sv =====
// Top level of the oriented box overlap test: two CORDIC/box paths, four axis lanes, merge.
// Depends on obb_pkg, obb_cordic, obb_box, obb_lane.
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_a_*, i_b_* box fields
//  output    out        o_valid / i_stall   o_boxes_intersect
//  config    in         i_cfg_we            i_cfg_wdata (overlap epsilon)
//
// One transaction per cycle sustained unless the output stalls; stages are the CORDIC,
// box build, projection lane and merge/output register. The CORDIC pipeline depth
// sets the latency. Reset (synchronous, active low) clears all valid bits and
// sets epsilon to 1. A stall at the output freezes the whole pipeline while the
// output register holds a result; bubbles never block acceptance.
`timescale 1ns / 1ps
module obb_overlap_test import obb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [EW-1:0]      i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [23:0] i_a_center_x,
    input  logic signed [23:0] i_a_center_y,
    input  logic [15:0]        i_a_heading,
    input  logic [15:0]        i_a_width,
    input  logic [15:0]        i_a_length,
    input  logic signed [23:0] i_b_center_x,
    input  logic signed [23:0] i_b_center_y,
    input  logic [15:0]        i_b_heading,
    input  logic [15:0]        i_b_width,
    input  logic [15:0]        i_b_length,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_boxes_intersect
);
    localparam int LAT = NIT + 2 + 2 + 4 + 1;

    logic [EW-1:0]  r_eps;
    logic [LAT-1:0] r_vld;
    logic           r_hit;
    logic           adv;

    // pipeline moves unless a finished result is held by the consumer
    assign adv     = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EW'(1);
            r_vld <= '0;
        end else begin
            if (i_cfg_we) r_eps <= i_cfg_wdata;
            if (adv) r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    t_geom                ga_in, gb_in, ga, gb;
    logic signed [TW-1:0] ca, sa, cb, sb;
    t_box                 box_a, box_b;
    logic [3:0]           fail;

    assign ga_in = '{cx: i_a_center_x, cy: i_a_center_y, w: i_a_width, l: i_a_length};
    assign gb_in = '{cx: i_b_center_x, cy: i_b_center_y, w: i_b_width, l: i_b_length};

    obb_cordic u_cordic_a (.i_clk(i_clk), .i_adv(adv), .i_heading(i_a_heading),
        .i_geom(ga_in), .o_cos(ca), .o_sin(sa), .o_geom(ga));
    obb_cordic u_cordic_b (.i_clk(i_clk), .i_adv(adv), .i_heading(i_b_heading),
        .i_geom(gb_in), .o_cos(cb), .o_sin(sb), .o_geom(gb));

    obb_box u_box_a (.i_clk(i_clk), .i_adv(adv), .i_eps(r_eps), .i_cos(ca),
        .i_sin(sa), .i_geom(ga), .o_box(box_a));
    obb_box u_box_b (.i_clk(i_clk), .i_adv(adv), .i_eps(r_eps), .i_cos(cb),
        .i_sin(sb), .i_geom(gb), .o_box(box_b));

    // lanes: A width axis, A length axis, B width axis, B length axis
    obb_lane u_lane0 (.i_clk(i_clk), .i_adv(adv), .i_eps(r_eps), .i_box_a(box_a),
        .i_box_b(box_b), .i_ax(box_a.ax[0]), .i_ay(box_a.ay[0]), .o_fail(fail[0]));
    obb_lane u_lane1 (.i_clk(i_clk), .i_adv(adv), .i_eps(r_eps), .i_box_a(box_a),
        .i_box_b(box_b), .i_ax(box_a.ax[1]), .i_ay(box_a.ay[1]), .o_fail(fail[1]));
    obb_lane u_lane2 (.i_clk(i_clk), .i_adv(adv), .i_eps(r_eps), .i_box_a(box_a),
        .i_box_b(box_b), .i_ax(box_b.ax[0]), .i_ay(box_b.ay[0]), .o_fail(fail[2]));
    obb_lane u_lane3 (.i_clk(i_clk), .i_adv(adv), .i_eps(r_eps), .i_box_a(box_a),
        .i_box_b(box_b), .i_ax(box_b.ax[1]), .i_ay(box_b.ay[1]), .o_fail(fail[3]));

    // merge: intersecting only when no axis separates
    always_ff @(posedge i_clk) begin
        if (adv) r_hit <= ~|fail;
    end

    assign o_valid           = r_vld[LAT-1];
    assign o_boxes_intersect = r_hit;
endmodule

// ===== rtl/obb_checker.sv =====
// Port-level checks for obb_overlap_test, bound to the top level.
// Depends on obb_overlap_test ports only.
`timescale 1ns / 1ps
module obb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_boxes_intersect
);
    a_stall_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow held output");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without a pending result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_boxes_intersect))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind obb_overlap_test obb_checker u_obb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall), .o_valid(o_valid),
    .i_stall(i_stall), .o_boxes_intersect(o_boxes_intersect)
);

// ===== dv/obb_overlap_checker.sv =====
// Checker for the oriented box overlap test: watches both channels, predicts the
// intersect flag from accepted input transactions and compares. Depends on obb_pkg.
`timescale 1ns / 1ps
module obb_overlap_checker import obb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [EW-1:0]      i_cfg_wdata,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic signed [23:0] i_a_cx,
    input  logic signed [23:0] i_a_cy,
    input  logic [15:0]        i_a_hd,
    input  logic [15:0]        i_a_w,
    input  logic [15:0]        i_a_l,
    input  logic signed [23:0] i_b_cx,
    input  logic signed [23:0] i_b_cy,
    input  logic [15:0]        i_b_hd,
    input  logic [15:0]        i_b_w,
    input  logic [15:0]        i_b_l,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_hit,
    output int                 o_errors,
    output int                 o_pending
);
    localparam int TB = 15;

    typedef struct {
        longint px[4];
        longint py[4];
        longint ax[2];
        longint ay[2];
    } box_geom_t;

    longint   eps_q;
    bit       hit_q[$];

    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint trig_round(longint q30);
        longint r;
        longint one;
        one = longint'(1) << TB;
        r = fshr(q30 + (longint'(1) << (30 - TB - 1)), 30 - TB);
        if (r > one) r = one;
        if (r < -one) r = -one;
        return r;
    endfunction

    task automatic sin_cos(input logic [15:0] hd, output longint c, output longint s);
        longint z, x, y, nx;
        bit flip;
        z = longint'(hd) * 65536;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z >= (longint'(1) << 31)) z -= longint'(1) << 32;
        if (z > (longint'(1) << 30)) begin
            z -= longint'(1) << 31;
            flip = 1;
        end else if (z < -(longint'(1) << 30)) begin
            z += longint'(1) << 31;
            flip = 1;
        end
        for (int i = 0; i < NIT; i++) begin
            if (z >= 0) begin
                nx = x - fshr(y, i);
                y = y + fshr(x, i);
                z -= longint'(atan_turn(i));
            end else begin
                nx = x + fshr(y, i);
                y = y - fshr(x, i);
                z += longint'(atan_turn(i));
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = trig_round(x);
        s = trig_round(y);
    endtask

    task automatic make_box(input longint cx, input longint cy, input logic [15:0] hd,
                            input longint w, input longint l, output box_geom_t b);
        longint c, s, dx, dy;
        longint sl[4];
        longint sw[4];
        sl = '{1, 1, -1, -1};
        sw = '{1, -1, -1, 1};
        sin_cos(hd, c, s);
        for (int k = 0; k < 4; k++) begin
            dx = sl[k] * l * c + sw[k] * w * s;
            dy = sl[k] * l * s - sw[k] * w * c;
            b.px[k] = cx + fshr(dx + (longint'(1) << TB), TB + 1);
            b.py[k] = cy + fshr(dy + (longint'(1) << TB), TB + 1);
        end
        b.ax[0] = (w > eps_q) ? -c : 0;
        b.ay[0] = (w > eps_q) ? -s : 0;
        b.ax[1] = (l > eps_q) ? s : 0;
        b.ay[1] = (l > eps_q) ? -c : 0;
    endtask

    function automatic void span(box_geom_t b, longint ax, longint ay,
                                 output longint lo, output longint hi);
        longint p;
        for (int k = 0; k < 4; k++) begin
            p = b.px[k] * ax + b.py[k] * ay;
            if (k == 0 || p < lo) lo = p;
            if (k == 0 || p > hi) hi = p;
        end
    endfunction

    task automatic predict_intersect();
        box_geom_t bx[2];
        longint alo, ahi, blo, bhi, ov, ax, ay;
        bit hit;
        make_box(i_a_cx, i_a_cy, i_a_hd, i_a_w, i_a_l, bx[0]);
        make_box(i_b_cx, i_b_cy, i_b_hd, i_b_w, i_b_l, bx[1]);
        hit = 1;
        for (int bi = 0; bi < 2; bi++) begin
            for (int ai = 0; ai < 2; ai++) begin
                ax = bx[bi].ax[ai];
                ay = bx[bi].ay[ai];
                span(bx[0], ax, ay, alo, ahi);
                span(bx[1], ax, ay, blo, bhi);
                if (alo > bhi || ahi < blo) ov = 0;
                else ov = (ahi < bhi ? ahi : bhi) - (alo > blo ? alo : blo);
                if (ov < (eps_q << TB)) hit = 0;
            end
        end
        hit_q = {hit_q, hit};
    endtask

    initial begin
        o_errors = 0;
        eps_q = 1;
    end

    assign o_pending = hit_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            eps_q = 1;
        end else begin
            if (i_cfg_we) eps_q = i_cfg_wdata;
            if (i_valid && !i_in_stall) predict_intersect();
            if (i_out_valid && !i_out_stall) begin
                if (hit_q.size() == 0) begin
                    $error("unexpected result transaction, boxes_intersect=%0b", i_hit);
                    o_errors++;
                end else begin
                    if (hit_q[0] !== i_hit) begin
                        $error("boxes_intersect: expected %0b actual %0b", hit_q[0], i_hit);
                        o_errors++;
                    end
                    void'(hit_q.pop_front());
                end
            end
        end
    end
endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the oriented box overlap test: clock, reset, stimulus, verdict.
// Depends on obb_pkg, the rtl, and obb_overlap_checker.
`timescale 1ns / 1ps
module tb_top;
    import obb_pkg::*;

    localparam int LATENCY  = 39;
    localparam int WDOG_MAX = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [EW-1:0]      i_cfg_wdata;
    logic               i_valid;
    logic               o_stall;
    logic signed [23:0] a_cx, a_cy, b_cx, b_cy;
    logic [15:0]        a_hd, a_w, a_l, b_hd, b_w, b_l;
    logic               o_valid;
    logic               i_stall;
    logic               o_hit;
    int                 n_err;
    int                 n_pend;
    int                 idle_cycles;
    bit                 drain_stall_free;

    obb_overlap_test dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_a_center_x(a_cx), .i_a_center_y(a_cy), .i_a_heading(a_hd),
        .i_a_width(a_w), .i_a_length(a_l),
        .i_b_center_x(b_cx), .i_b_center_y(b_cy), .i_b_heading(b_hd),
        .i_b_width(b_w), .i_b_length(b_l),
        .o_valid(o_valid), .i_stall(i_stall), .o_boxes_intersect(o_hit)
    );

    obb_overlap_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .i_in_stall(o_stall),
        .i_a_cx(a_cx), .i_a_cy(a_cy), .i_a_hd(a_hd), .i_a_w(a_w), .i_a_l(a_l),
        .i_b_cx(b_cx), .i_b_cy(b_cy), .i_b_hd(b_hd), .i_b_w(b_w), .i_b_l(b_l),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_hit(o_hit),
        .o_errors(n_err), .o_pending(n_pend)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("obb_overlap_test: mismatch");
            $finish;
        end
    end

    // Receiver: random stall per result, sometimes long stall-free stretches.
    initial begin
        int gap;
        int burst;
        i_stall = 0;
        burst = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (drain_stall_free) gap = 0;
            else if (burst > 0) begin
                gap = 0;
                burst--;
            end else begin
                gap = $urandom_range(0, 16);
                if ($urandom_range(0, 9) == 0) burst = $urandom_range(20, 60);
            end
            if (gap > 0) begin
                i_stall <= 1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 0;
            @(posedge i_clk iff o_valid);
        end
    end

    // Send one transaction after the caller's pre-gap; waits for acceptance.
    task automatic send_pair(input logic signed [23:0] acx, acy, input logic [15:0] ahd,
                             aw, al, input logic signed [23:0] bcx, bcy,
                             input logic [15:0] bhd, bw, bl, input int gap);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        a_cx <= acx; a_cy <= acy; a_hd <= ahd; a_w <= aw; a_l <= al;
        b_cx <= bcx; b_cy <= bcy; b_hd <= bhd; b_w <= bw; b_l <= bl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (n_pend > 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_eps(input logic [15:0] v);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    // Random pair: mostly near-neighbours with modest sizes so both verdicts
    // show up; a share is fully random over every field bit.
    task automatic send_random(input int gap);
        logic signed [23:0] acx, acy, bcx, bcy;
        logic [15:0] aw, al, bw, bl;
        if ($urandom_range(0, 4) == 0) begin
            acx = 24'($urandom); acy = 24'($urandom);
            bcx = 24'($urandom); bcy = 24'($urandom);
            aw = 16'($urandom); al = 16'($urandom);
            bw = 16'($urandom); bl = 16'($urandom);
        end else begin
            acx = 24'($urandom_range(0, 8191)) - 24'sd4096;
            acy = 24'($urandom_range(0, 8191)) - 24'sd4096;
            bcx = acx + 24'($urandom_range(0, 4095)) - 24'sd2048;
            bcy = acy + 24'($urandom_range(0, 4095)) - 24'sd2048;
            aw = 16'($urandom_range(0, 2048)); al = 16'($urandom_range(0, 2048));
            bw = 16'($urandom_range(0, 2048)); bl = 16'($urandom_range(0, 2048));
            if ($urandom_range(0, 15) == 0) aw = 16'($urandom_range(0, 8));
        end
        send_pair(acx, acy, 16'($urandom), aw, al, bcx, bcy, 16'($urandom), bw, bl, gap);
    endtask

    initial begin
        logic [15:0] eps_set[5];
        int gap;
        eps_set = '{16'd1, 16'd0, 16'd65535, 16'd12, 16'd200};
        i_rst_n = 0; i_cfg_we = 0; i_cfg_wdata = '0; i_valid = 0;
        a_cx = 0; a_cy = 0; a_hd = 0; a_w = 0; a_l = 0;
        b_cx = 0; b_cy = 0; b_hd = 0; b_w = 0; b_l = 0;
        drain_stall_free = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed, reset epsilon: identical boxes, touching, separated,
        // short edges, extreme centres and sizes, quadrant headings.
        send_pair(0, 0, 16'h0000, 16'h0100, 16'h0200, 0, 0, 16'h0000, 16'h0100, 16'h0200, 0);
        send_pair(0, 0, 16'h0000, 16'h0100, 16'h0100, 256, 0, 16'h0000, 16'h0100, 16'h0100, 0);
        send_pair(0, 0, 16'h0000, 16'h0100, 16'h0100, 255, 0, 16'h0000, 16'h0100, 16'h0100, 1);
        send_pair(0, 0, 16'h4000, 16'h0100, 16'h0100, 1000, 0, 16'h8000, 16'h0100, 16'h0100, 0);
        send_pair(0, 0, 16'hC000, 16'h0001, 16'h0200, 0, 0, 16'h2000, 16'h0100, 16'h0100, 0);
        send_pair(0, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 16'h0000, 16'h0000, 16'h0000, 2);
        send_pair(24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  24'sh800000, 24'sh800000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 0);
        send_pair(24'sh800000, 24'sh7FFFFF, 16'h8001, 16'hFFFF, 16'h0002,
                  24'sh800000, 24'sh7FFFFF, 16'h4001, 16'h0002, 16'hFFFF, 0);
        send_pair(24'sh7FFFFF, 24'sh800000, 16'h2000, 16'hFFFF, 16'hFFFF,
                  24'sh7FFFF0, 24'sh800010, 16'hE000, 16'hFFFF, 16'hFFFF, 0);
        send_pair(0, 0, 16'h1234, 16'h0300, 16'h0500, 100, -100, 16'hABCD, 16'h0400, 16'h0200, 3);
        drain();

        // Phases over epsilon settings, extremes included; random pairs each.
        foreach (eps_set[p]) begin
            write_eps(eps_set[p]);
            if (p == 1) begin
                send_pair(0, 0, 16'h0000, 16'h0000, 16'h0000,
                          24'sh7FFFFF, 0, 16'h0000, 16'h0000, 16'h0000, 0);
            end
            for (int n = 0; n < 160; n++) begin
                gap = (n % 50 < 15) ? 0 : $urandom_range(0, 16);
                send_random(gap);
            end
            drain();
        end

        drain_stall_free = 1;
        i_valid <= 0;
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_err == 0 && n_pend == 0) begin
            $display("obb_overlap_test: match");
        end else begin
            $display("obb_overlap_test: mismatch");
        end
        $finish;
    end
endmodule
